// File: design/ipcsum_pkg.sv
// Shared types, constants and helpers for the IPv4 / transport checksum core.
`timescale 1ns / 1ps
package ipcsum_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned OFFSET_W  = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OFFSET_W-1:0] IP_CSUM_OFFSET_RST  = 6'd10;
  localparam logic [OFFSET_W-1:0] SEG_CSUM_OFFSET_RST = 6'd16;

  localparam logic [POS_W-1:0] PROTO_POS  = 16'd9;
  localparam logic [POS_W-1:0] ADDR_FIRST = 16'd12;
  localparam logic [POS_W-1:0] ADDR_LAST  = 16'd19;

  localparam logic SEC_HEADER  = 1'b0;
  localparam logic SEC_SEGMENT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IP_CSUM_OFFSET  = 1'b0,
    CFG_SEG_CSUM_OFFSET = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] ip_csum_offset;
    logic [OFFSET_W-1:0] seg_csum_offset;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              section;
    logic              last;
    logic              include_pseudo;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] checksum;
    logic              which_section;
  } result_t;

  // Fold an 18-bit sum of up to four 16-bit words down to 16 bits
  // with end-around carry.
  function automatic logic [WORD_W-1:0] fold18(input logic [WORD_W+1:0] s);
    logic [WORD_W:0] f1;
    logic [WORD_W:0] f2;
    f1 = {1'b0, s[WORD_W-1:0]} + {{(WORD_W-1){1'b0}}, s[WORD_W+1:WORD_W]};
    f2 = {1'b0, f1[WORD_W-1:0]} + {{WORD_W{1'b0}}, f1[WORD_W]};
    return f2[WORD_W-1:0];
  endfunction

endpackage

// File: design/ipcsum_cfg.sv
// Configuration registers: checksum field offsets for header and segment.
`timescale 1ns / 1ps
module ipcsum_cfg
  import ipcsum_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFFSET_W-1:0]  cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_IP_CSUM_OFFSET:  cfg_next.ip_csum_offset  = cfg_data;
        CFG_SEG_CSUM_OFFSET: cfg_next.seg_csum_offset = cfg_data;
        default:             cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ip_csum_offset  <= IP_CSUM_OFFSET_RST;
      cfg.seg_csum_offset <= SEG_CSUM_OFFSET_RST;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// File: design/ipcsum_in_reg.sv
// Input register: holds one accepted byte beat until the accumulator takes it.
`timescale 1ns / 1ps
module ipcsum_in_reg
  import ipcsum_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  byte_valid,
  output logic  byte_stall,
  input  item_t item_in,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  // Stall only while a held beat cannot move on this cycle.
  assign byte_stall = item_valid && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!byte_stall) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      item <= item_in;
    end
  end

endmodule

// File: design/ipcsum_accum.sv
// Running ones' complement sums, byte pairing and pseudo-header capture.
`timescale 1ns / 1ps
module ipcsum_accum
  import ipcsum_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_fire,
  input  item_t   item,
  output result_t result
);

  logic [WORD_W-1:0] run_sum;
  logic [WORD_W-1:0] pseudo_sum;
  logic [POS_W-1:0]  pos;
  logic [DATA_W-1:0] pend;
  logic              cur_sec;

  logic              sec_change;
  logic [POS_W-1:0]  pos_eff;
  logic [POS_W-1:0]  pos_inc;
  logic [WORD_W-1:0] sum_eff;
  logic [POS_W-1:0]  off;
  logic [DATA_W-1:0] b;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] ps_base;
  logic [WORD_W-1:0] ps_add;
  logic [WORD_W-1:0] pseudo_next;
  logic              add_pseudo;
  logic [WORD_W-1:0] ps_term;
  logic [WORD_W-1:0] len_term;
  logic [WORD_W+1:0] total;
  logic [WORD_W-1:0] total_fold;

  always_comb begin
    sec_change = item.section != cur_sec;
    pos_eff    = sec_change ? '0 : pos;
    sum_eff    = sec_change ? '0 : run_sum;
    pos_inc    = pos_eff + 16'd1;
    off        = (item.section == SEC_HEADER) ? POS_W'(cfg.ip_csum_offset)
                                               : POS_W'(cfg.seg_csum_offset);
    // Read the stored checksum field as zero.
    b = (pos_eff == off || pos_eff == off + 16'd1) ? '0 : item.data_byte;

    if (pos_eff[0]) begin
      word = {pend, b};
    end else if (item.last) begin
      word = {b, 8'h00};
    end else begin
      word = '0;
    end

    // Pseudo-header: protocol byte and both addresses, restart on a new header.
    ps_base = (pos_eff == '0) ? '0 : pseudo_sum;
    if (pos_eff == PROTO_POS) begin
      ps_add = {8'h00, b};
    end else if (pos_eff inside {[ADDR_FIRST:ADDR_LAST]}) begin
      ps_add = pos_eff[0] ? {8'h00, b} : {b, 8'h00};
    end else begin
      ps_add = '0;
    end
    pseudo_next = (item.section == SEC_HEADER)
                ? fold18({2'b00, ps_base} + {2'b00, ps_add})
                : pseudo_sum;

    add_pseudo = (item.section == SEC_SEGMENT) && item.last && item.include_pseudo;
    ps_term    = add_pseudo ? pseudo_sum : '0;
    len_term   = add_pseudo ? pos_inc : '0;
    total      = {2'b00, sum_eff} + {2'b00, word} + {2'b00, ps_term} + {2'b00, len_term};
    total_fold = fold18(total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum    <= '0;
      pseudo_sum <= '0;
      pos        <= '0;
      pend       <= '0;
      cur_sec    <= SEC_HEADER;
    end else if (item_fire) begin
      cur_sec    <= item.section;
      pseudo_sum <= pseudo_next;
      if (!pos_eff[0] && !item.last) begin
        pend <= b;
      end
      if (item.last) begin
        run_sum <= '0;
        pos     <= '0;
      end else begin
        run_sum <= total_fold;
        pos     <= pos_inc;
      end
    end
  end

  assign result.checksum      = ~total_fold;
  assign result.which_section = item.section;

endmodule

// File: design/ipcsum_out_reg.sv
// Result register: holds one checksum beat until the consumer takes it.
`timescale 1ns / 1ps
module ipcsum_out_reg
  import ipcsum_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  output logic    free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      result <= result_in;
    end
  end

endmodule

// File: design/ip_and_transport_checksum_core.sv
// Top level of the IPv4 header and transport checksum core.
//
//   channel   direction  handshake                   payload
//   byte      in         byte_valid / byte_stall     data_byte, section, last, include_pseudo
//   result    out        result_valid / result_stall checksum, which_section
//   cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One byte beat is taken every cycle while byte_stall is low. An accepted byte sits
// in the input register while the accumulator adds it; a last byte's checksum is loaded
// into the result register as that byte leaves the input register, and result_valid
// is driven from the result register. The 16-bit end-around add in the accumulator
// sets the pace. Reset is synchronous, clears the sums and position and sets the
// offsets to ip 10, segment 16. A stalled result holds the result register and,
// only when a last byte waits behind it, the byte side.
`timescale 1ns / 1ps
module ip_and_transport_checksum_core
  import ipcsum_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [DATA_W-1:0]    data_byte,
  input  logic                 section,
  input  logic                 last,
  input  logic                 include_pseudo,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [WORD_W-1:0]    checksum,
  output logic                 which_section,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFFSET_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    item_fire;
  logic    out_free;
  result_t acc_result;
  result_t result;

  assign item_in = '{data_byte: data_byte, section: section, last: last,
                     include_pseudo: include_pseudo};

  // A byte with no result moves on at once; a last byte needs a free slot.
  assign item_take = !item.last || out_free;
  assign item_fire = item_valid && item_take;

  ipcsum_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipcsum_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  ipcsum_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_fire (item_fire),
    .item      (item),
    .result    (acc_result)
  );

  ipcsum_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (item_fire && item.last),
    .result_in    (acc_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign checksum      = result.checksum;
  assign which_section = result.which_section;

endmodule
